### rtl/crtc_pkg.sv
// crtc_pkg: shared types and constants for the crt controller register file
// no dependencies; imported by crtc_register_file_vblank_core
package crtc_pkg;

  // field widths
  localparam int unsigned ADDR_W  = 14;
  localparam int unsigned HT_W    = 9;
  localparam int unsigned VT_W    = 8;
  localparam int unsigned VA_W    = 5;
  localparam int unsigned VD_W    = 7;
  localparam int unsigned LPR_W   = 6;
  localparam int unsigned LINE_W  = 5;
  localparam int unsigned LEN_W   = 20;

  // datapath of the shared add / subtract unit
  localparam int unsigned ACC_W     = 22;
  localparam int unsigned MPL_W     = HT_W;
  localparam int unsigned MUL_STEPS = MPL_W;
  // dividend bits, unscaled lengths stay below 2**21
  localparam int unsigned DIV_STEPS = LEN_W + 1;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam int unsigned CPC_DEFAULT = 2;

  // bus functions
  typedef enum logic [2:0] {
    FUNC_SEL    = 3'd0,
    FUNC_WR     = 3'd1,
    FUNC_RD     = 3'd2,
    FUNC_STATUS = 3'd3,
    FUNC_LPEN   = 3'd4,
    FUNC_TICK   = 3'd5
  } crtc_func_e;

  // register numbers
  localparam logic [4:0] REG_HTOTAL     = 5'd0;
  localparam logic [4:0] REG_VTOTAL     = 5'd4;
  localparam logic [4:0] REG_VADJUST    = 5'd5;
  localparam logic [4:0] REG_VDISPLAYED = 5'd6;
  localparam logic [4:0] REG_LINES      = 5'd9;
  localparam logic [4:0] REG_CUR_START  = 5'd10;
  localparam logic [4:0] REG_CUR_END    = 5'd11;
  localparam logic [4:0] REG_START_HI   = 5'd12;
  localparam logic [4:0] REG_START_LO   = 5'd13;
  localparam logic [4:0] REG_CURSOR_HI  = 5'd14;
  localparam logic [4:0] REG_CURSOR_LO  = 5'd15;
  localparam logic [4:0] REG_LPEN_HI    = 5'd16;
  localparam logic [4:0] REG_LPEN_LO    = 5'd17;
  localparam logic [4:0] REG_UPD_HI     = 5'd18;
  localparam logic [4:0] REG_UPD_LO     = 5'd19;
  localparam logic [4:0] REG_UPD_STROBE = 5'd31;

  localparam logic [7:0] STATUS_BASE = 8'h80;
  localparam logic [7:0] RD_UNMAPPED = 8'hFF;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        data;
    logic [ADDR_W-1:0] lpen_addr;
  } crtc_cmd_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              read_unmapped;
    logic              vblank;
    logic              lpen_full;
    logic              update_strobe;
    logic [ADDR_W-1:0] update_addr;
    logic [ADDR_W-1:0] display_start;
    logic [ADDR_W-1:0] cursor_pos;
    logic [LINE_W-1:0] cursor_first_line;
    logic [LINE_W-1:0] cursor_last_line;
    logic [1:0]        cursor_blink_mode;
  } crtc_res_t;

endpackage

### rtl/crtc_register_file_vblank_core.sv
// crtc_register_file_vblank_core: register side of a 6545-style crt controller
// depends on crtc_pkg for the word types, widths and register numbers
//
// One bus word is taken when start is high and busy is low; exactly one result
// word follows on res_o, marked by result_valid_o for one cycle, and the
// receiver cannot stall it. Selects, data reads, status reads, light pen
// strobes, ticks, unused function codes and writes to non-timing registers give
// their result in the cycle after the word is taken. A data write to a timing
// register (R0, R4, R5, R9) recomputes frame and blanking lengths on one shared
// add / subtract unit: four 9-step shift-add multiplies (the second subtracting),
// one add, then two 21-step add-shift multiplies by the rounded-up reciprocal of
// CHAR_PER_CPU_CLOCKS, whose upper half is the truncated quotient. busy stays
// high over that whole run.
module crtc_register_file_vblank_core
  import crtc_pkg::*;
#(
  parameter int unsigned CHAR_PER_CPU_CLOCKS = CPC_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  crtc_cmd_t cmd_i,
  output logic      result_valid_o,
  output crtc_res_t res_o
);

  // 2**DIV_STEPS / clock ratio rounded up; exact for dividends below 2**DIV_STEPS
  // and ratios of 1 to 4
  localparam logic [ACC_W-1:0] RECIP =
    ACC_W'(((1 << DIV_STEPS) + CHAR_PER_CPU_CLOCKS - 1) / CHAR_PER_CPU_CLOCKS);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_M1   = 3'd1;  // vert_total * lines_per_row
  localparam logic [2:0] ST_A1   = 3'd2;  // + vert_adjust
  localparam logic [2:0] ST_M2   = 3'd3;  // - vert_displayed * lines_per_row
  localparam logic [2:0] ST_M3   = 3'd4;  // frame rows * horiz_total
  localparam logic [2:0] ST_M4   = 3'd5;  // blank rows * horiz_total
  localparam logic [2:0] ST_D3   = 3'd6;  // frame / clock ratio
  localparam logic [2:0] ST_D4   = 3'd7;  // blank / clock ratio

  // architectural registers
  logic [4:0]        sel_q, sel_d;
  logic [HT_W-1:0]   ht_q, ht_d;
  logic [VT_W-1:0]   vt_q, vt_d;
  logic [VA_W-1:0]   va_q, va_d;
  logic [VD_W-1:0]   vd_q, vd_d;
  logic [LPR_W-1:0]  lpr_q, lpr_d;
  logic [LINE_W-1:0] cs_q, cs_d;
  logic [LINE_W-1:0] ce_q, ce_d;
  logic [1:0]        blink_q, blink_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [ADDR_W-1:0] pen_addr_q, pen_addr_d;
  logic              pen_q, pen_d;
  logic [ADDR_W-1:0] upd_q, upd_d;
  logic [LEN_W-1:0]  frame_q, frame_d;
  logic [LEN_W-1:0]  blank_q, blank_d;
  logic [LEN_W-1:0]  phase_q, phase_d;

  // sequencer and datapath registers
  logic [2:0]        st_q, st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  mcand_q, mcand_d;
  logic [MPL_W-1:0]  mplier_q, mplier_d;
  logic [ACC_W-1:0]  ff_q, ff_d;   // frame length in progress
  logic [ACC_W-1:0]  bb_q, bb_d;   // blank length in progress

  // result register
  logic              valid_q, valid_d;
  crtc_res_t         res_q, res_d;

  // shared add / subtract unit
  logic [ACC_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sub;

  logic              accept;
  logic              timing_wr;
  logic              emit;
  logic              mul_state, div_state;
  logic              step_done;
  logic [ACC_W-1:0]  quot_next;
  logic [LEN_W-1:0]  phase_inc;
  logic [7:0]        rd_data;
  logic              rd_unmapped;
  logic              upd_strobe;
  logic [ADDR_W-1:0] upd_out;

  function automatic logic [LEN_W-1:0] sat_len(input logic [ACC_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (|v[ACC_W-1:LEN_W]) r = LEN_MAX;
    else                   r = v[LEN_W-1:0];
    return r;
  endfunction

  assign accept    = start & ~busy;
  assign busy      = (st_q != ST_IDLE);
  assign mul_state = (st_q == ST_M1) || (st_q == ST_M2) || (st_q == ST_M3) || (st_q == ST_M4);
  assign div_state = (st_q == ST_D3) || (st_q == ST_D4);
  assign step_done = (cnt_q == '0);

  // reciprocal step: the sum shifts right, the dropped bit lies below the quotient
  assign quot_next = {1'b0, alu_sum[ACC_W-1:1]};

  assign phase_inc = phase_q + LEN_W'(1);

  // operand selection for the shared unit
  always_comb begin
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (st_q)
      ST_M1, ST_M3, ST_M4: begin
        alu_b = mplier_q[0] ? mcand_q : '0;
      end
      ST_A1: begin
        alu_b = ACC_W'(va_q);
      end
      ST_M2: begin
        alu_b   = mplier_q[0] ? mcand_q : '0;
        alu_sub = 1'b1;
      end
      ST_D3, ST_D4: begin
        alu_b = mcand_q[0] ? RECIP : '0;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);

  // next state
  always_comb begin
    sel_d      = sel_q;
    ht_d       = ht_q;
    vt_d       = vt_q;
    va_d       = va_q;
    vd_d       = vd_q;
    lpr_d      = lpr_q;
    cs_d       = cs_q;
    ce_d       = ce_q;
    blink_d    = blink_q;
    cur_d      = cur_q;
    start_d    = start_q;
    pen_addr_d = pen_addr_q;
    pen_d      = pen_q;
    upd_d      = upd_q;
    frame_d    = frame_q;
    blank_d    = blank_q;
    phase_d    = phase_q;
    st_d       = st_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;
    ff_d       = ff_q;
    bb_d       = bb_q;
    timing_wr  = 1'b0;
    emit       = 1'b0;
    rd_data    = '0;
    rd_unmapped = 1'b0;
    upd_strobe = 1'b0;
    upd_out    = '0;

    // common step of the serial multiplies
    if (mul_state) begin
      acc_d    = alu_sum;
      mcand_d  = {mcand_q[ACC_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[MPL_W-1:1]};
      cnt_d    = cnt_q - CNT_W'(1);
    end
    // dividend bits enter lsb first from mcand
    if (div_state) begin
      acc_d   = quot_next;
      mcand_d = {1'b0, mcand_q[ACC_W-1:1]};
      cnt_d   = cnt_q - CNT_W'(1);
    end

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.func)
            FUNC_SEL: begin
              sel_d = cmd_i.data[4:0];
            end
            FUNC_WR: begin
              timing_wr = sel_q inside {REG_HTOTAL, REG_VTOTAL, REG_VADJUST, REG_LINES};
              case (sel_q)
                REG_HTOTAL:     ht_d = {1'b0, cmd_i.data} + HT_W'(1);
                REG_VTOTAL:     vt_d = {1'b0, cmd_i.data[6:0]} + VT_W'(1);
                REG_VADJUST:    va_d = cmd_i.data[4:0];
                REG_VDISPLAYED: vd_d = cmd_i.data[6:0];
                REG_LINES:      lpr_d = {1'b0, cmd_i.data[4:0]} + LPR_W'(1);
                REG_CUR_START: begin
                  cs_d    = cmd_i.data[4:0];
                  blink_d = cmd_i.data[6:5];
                end
                REG_CUR_END:    ce_d = cmd_i.data[4:0];
                REG_START_HI:   start_d = {cmd_i.data[5:0], start_q[7:0]};
                REG_START_LO:   start_d = {start_q[ADDR_W-1:8], cmd_i.data};
                REG_CURSOR_HI:  cur_d = {cmd_i.data[5:0], cur_q[7:0]};
                REG_CURSOR_LO:  cur_d = {cur_q[ADDR_W-1:8], cmd_i.data};
                REG_UPD_HI:     upd_d = {cmd_i.data[5:0], upd_q[7:0]};
                REG_UPD_LO:     upd_d = {upd_q[ADDR_W-1:8], cmd_i.data};
                REG_UPD_STROBE: begin
                  upd_strobe = 1'b1;
                  upd_out    = upd_q;
                end
                default: begin
                  upd_strobe = 1'b0;
                end
              endcase
              if (timing_wr) begin
                // start with vert_total * lines_per_row from the new values
                st_d     = ST_M1;
                acc_d    = '0;
                mcand_d  = ACC_W'(vt_d);
                mplier_d = MPL_W'(lpr_d);
                cnt_d    = CNT_W'(MUL_STEPS - 1);
              end
            end
            FUNC_RD: begin
              case (sel_q)
                REG_CURSOR_HI: rd_data = {2'b00, cur_q[ADDR_W-1:8]};
                REG_CURSOR_LO: rd_data = cur_q[7:0];
                REG_LPEN_HI: begin
                  rd_data = {2'b00, pen_addr_q[ADDR_W-1:8]};
                  pen_d   = 1'b0;
                end
                REG_LPEN_LO: begin
                  rd_data = pen_addr_q[7:0];
                  pen_d   = 1'b0;
                end
                default: begin
                  rd_data     = RD_UNMAPPED;
                  rd_unmapped = 1'b1;
                end
              endcase
            end
            FUNC_STATUS: begin
              rd_data = STATUS_BASE | {1'b0, pen_q, (phase_q < blank_q), 5'b0};
            end
            FUNC_LPEN: begin
              if (!pen_q) begin
                pen_d      = 1'b1;
                pen_addr_d = cmd_i.lpen_addr;
              end
            end
            FUNC_TICK: begin
              phase_d = (phase_inc >= frame_q) ? '0 : phase_inc;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
          emit = ~timing_wr;
        end
      end
      ST_M1: begin
        if (step_done) st_d = ST_A1;
      end
      ST_A1: begin
        // frame rows done; blank rows continue from the same sum
        ff_d     = alu_sum;
        acc_d    = alu_sum;
        mcand_d  = ACC_W'(vd_q);
        mplier_d = MPL_W'(lpr_q);
        cnt_d    = CNT_W'(MUL_STEPS - 1);
        st_d     = ST_M2;
      end
      ST_M2: begin
        if (step_done) begin
          // negative blank rows clamp to zero
          bb_d     = alu_sum[ACC_W-1] ? '0 : alu_sum;
          acc_d    = '0;
          mcand_d  = ff_q;
          mplier_d = ht_q;
          cnt_d    = CNT_W'(MUL_STEPS - 1);
          st_d     = ST_M3;
        end
      end
      ST_M3: begin
        if (step_done) begin
          ff_d     = alu_sum;
          acc_d    = '0;
          mcand_d  = bb_q;
          mplier_d = ht_q;
          cnt_d    = CNT_W'(MUL_STEPS - 1);
          st_d     = ST_M4;
        end
      end
      ST_M4: begin
        if (step_done) begin
          bb_d    = alu_sum;
          acc_d   = '0;
          mcand_d = ff_q;
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          st_d    = ST_D3;
        end
      end
      ST_D3: begin
        if (step_done) begin
          ff_d    = quot_next;
          acc_d   = '0;
          mcand_d = bb_q;
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          st_d    = ST_D4;
        end
      end
      ST_D4: begin
        if (step_done) begin
          frame_d = (sat_len(ff_q) == '0) ? LEN_W'(1) : sat_len(ff_q);
          blank_d = sat_len(quot_next);
          phase_d = '0;
          st_d    = ST_IDLE;
          emit    = 1'b1;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // result word, built from the state after this word
  always_comb begin
    valid_d                   = emit;
    res_d.read_data           = rd_data;
    res_d.read_unmapped       = rd_unmapped;
    res_d.vblank              = (phase_d < blank_d);
    res_d.lpen_full           = pen_d;
    res_d.update_strobe       = upd_strobe;
    res_d.update_addr         = upd_out;
    res_d.display_start       = start_d;
    res_d.cursor_pos          = cur_d;
    res_d.cursor_first_line   = cs_d;
    res_d.cursor_last_line    = ce_d;
    res_d.cursor_blink_mode   = blink_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= '0;
      ht_q       <= '0;
      vt_q       <= '0;
      va_q       <= '0;
      vd_q       <= '0;
      lpr_q      <= '0;
      cs_q       <= '0;
      ce_q       <= '0;
      blink_q    <= '0;
      cur_q      <= '0;
      start_q    <= '0;
      pen_addr_q <= '0;
      pen_q      <= 1'b0;
      upd_q      <= '0;
      frame_q    <= LEN_W'(1);
      blank_q    <= '0;
      phase_q    <= '0;
      st_q       <= ST_IDLE;
      cnt_q      <= '0;
      valid_q    <= 1'b0;
    end else begin
      sel_q      <= sel_d;
      ht_q       <= ht_d;
      vt_q       <= vt_d;
      va_q       <= va_d;
      vd_q       <= vd_d;
      lpr_q      <= lpr_d;
      cs_q       <= cs_d;
      ce_q       <= ce_d;
      blink_q    <= blink_d;
      cur_q      <= cur_d;
      start_q    <= start_d;
      pen_addr_q <= pen_addr_d;
      pen_q      <= pen_d;
      upd_q      <= upd_d;
      frame_q    <= frame_d;
      blank_q    <= blank_d;
      phase_q    <= phase_d;
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      valid_q    <= valid_d;
    end
  end

  // datapath and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    ff_q     <= ff_d;
    bb_q     <= bb_d;
    res_q    <= res_d;
  end

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

endmodule

### tb/crtc_register_file_vblank_core_tb.sv
// self-checking bench for the crt controller register file and its vblank timing
// depends on crtc_pkg and crtc_register_file_vblank_core; a directed table first, then random words
`timescale 1ns / 100ps

module crtc_register_file_vblank_core_tb;
  import crtc_pkg::*;

  localparam int unsigned CPC = CPC_DEFAULT;
  // bench stops well past the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_WORDS = 1300;
  localparam int unsigned DRAIN_CYCLES = 100;

  // bus functions the block does not define: must report state and change nothing
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  // one row of the directed table; pinned rows carry a hand-typed read byte
  typedef struct packed {
    crtc_cmd_t  cmd;
    logic       pin;
    logic [7:0] rd;
    logic       unm;
  } bus_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  crtc_cmd_t cmd_i;
  logic      result_valid_o;
  crtc_res_t res_o;

  // pinned read byte that travels along with the word on the bus
  logic       pin_chk;
  logic [7:0] pin_rd;
  logic       pin_unm;

  crtc_res_t   res_due[$];
  int unsigned words_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_sent;

  // predictor copy of the register file
  logic [4:0]        sel_reg;
  logic [8:0]        h_total;
  logic [7:0]        v_total;
  logic [4:0]        v_adj;
  logic [6:0]        v_disp;
  logic [5:0]        row_lines;
  logic [4:0]        cur_first;
  logic [4:0]        cur_last;
  logic [1:0]        blink_mode;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] disp_addr;
  logic [ADDR_W-1:0] pen_latch;
  logic              pen_full;
  logic [ADDR_W-1:0] upd_latch;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  blank_len;
  logic [LEN_W-1:0]  phase;

  crtc_register_file_vblank_core #(
    .CHAR_PER_CPU_CLOCKS(CPC)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .res_o         (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // frame and blanking lengths in cpu clocks; any timing write restarts the frame
  function automatic void refresh_frame_timing();
    longint f;
    longint inner;
    longint b;
    f = longint'(h_total) * (longint'(v_total) * longint'(row_lines) + longint'(v_adj)) / CPC;
    frame_len = (f > longint'(LEN_MAX)) ? LEN_MAX : f[LEN_W-1:0];
    // zero frame length still needs one clock per frame
    if (frame_len == '0) frame_len = LEN_W'(1);
    inner = (longint'(v_total) - longint'(v_disp)) * longint'(row_lines) + longint'(v_adj);
    // displayed lines covering all total lines plus adjust: no blanking at all
    if (inner <= 0) begin
      blank_len = '0;
    end else begin
      b = longint'(h_total) * inner / CPC;
      blank_len = (b > longint'(LEN_MAX)) ? LEN_MAX : b[LEN_W-1:0];
    end
    phase = '0;
  endfunction

  // advance the predictor by one bus word and return the result it should produce
  function automatic crtc_res_t crtc_step(crtc_cmd_t w);
    crtc_res_t r;
    logic [7:0] d;
    r = '0;
    d = w.data;
    case (w.func)
      FUNC_SEL: sel_reg = d[4:0];
      FUNC_WR: begin
        case (sel_reg)
          REG_HTOTAL: begin
            h_total = {1'b0, d} + 9'd1;
            refresh_frame_timing();
          end
          REG_VTOTAL: begin
            v_total = {1'b0, d[6:0]} + 8'd1;
            refresh_frame_timing();
          end
          REG_VADJUST: begin
            v_adj = d[4:0];
            refresh_frame_timing();
          end
          // displayed rows only take effect at the next timing write
          REG_VDISPLAYED: v_disp = d[6:0];
          REG_LINES: begin
            row_lines = {1'b0, d[4:0]} + 6'd1;
            refresh_frame_timing();
          end
          REG_CUR_START: begin
            cur_first  = d[4:0];
            blink_mode = d[6:5];
          end
          REG_CUR_END:   cur_last = d[4:0];
          REG_START_HI:  disp_addr[13:8] = d[5:0];
          REG_START_LO:  disp_addr[7:0] = d;
          REG_CURSOR_HI: cur_addr[13:8] = d[5:0];
          REG_CURSOR_LO: cur_addr[7:0] = d;
          REG_UPD_HI:    upd_latch[13:8] = d[5:0];
          REG_UPD_LO:    upd_latch[7:0] = d;
          default: ;
        endcase
        if (sel_reg == REG_UPD_STROBE) begin
          r.update_strobe = 1'b1;
          r.update_addr   = upd_latch;
        end
      end
      FUNC_RD: begin
        case (sel_reg)
          REG_CURSOR_HI: r.read_data = {2'b00, cur_addr[13:8]};
          REG_CURSOR_LO: r.read_data = cur_addr[7:0];
          // reading either pen byte frees the latch
          REG_LPEN_HI: begin
            r.read_data = {2'b00, pen_latch[13:8]};
            pen_full = 1'b0;
          end
          REG_LPEN_LO: begin
            r.read_data = pen_latch[7:0];
            pen_full = 1'b0;
          end
          default: begin
            r.read_data     = RD_UNMAPPED;
            r.read_unmapped = 1'b1;
          end
        endcase
      end
      FUNC_STATUS:
        r.read_data = STATUS_BASE | {1'b0, pen_full, phase < blank_len, 5'b00000};
      // a full pen latch keeps its first address
      FUNC_LPEN:
        if (!pen_full) begin
          pen_full  = 1'b1;
          pen_latch = w.lpen_addr;
        end
      FUNC_TICK: begin
        phase = phase + 1'b1;
        if (phase >= frame_len) phase = '0;
      end
      default: ;
    endcase
    r.vblank            = phase < blank_len;
    r.lpen_full         = pen_full;
    r.display_start     = disp_addr;
    r.cursor_pos        = cur_addr;
    r.cursor_first_line = cur_first;
    r.cursor_last_line  = cur_last;
    r.cursor_blink_mode = blink_mode;
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      errors++;
    end
  endtask

  task automatic check_word(input crtc_res_t e, input crtc_res_t a);
    cmp_field("read_data", e.read_data, a.read_data);
    cmp_field("read_unmapped", e.read_unmapped, a.read_unmapped);
    cmp_field("vblank", e.vblank, a.vblank);
    cmp_field("lpen_full", e.lpen_full, a.lpen_full);
    cmp_field("update_strobe", e.update_strobe, a.update_strobe);
    cmp_field("update_addr", e.update_addr, a.update_addr);
    cmp_field("display_start", e.display_start, a.display_start);
    cmp_field("cursor_pos", e.cursor_pos, a.cursor_pos);
    cmp_field("cursor_first_line", e.cursor_first_line, a.cursor_first_line);
    cmp_field("cursor_last_line", e.cursor_last_line, a.cursor_last_line);
    cmp_field("cursor_blink_mode", e.cursor_blink_mode, a.cursor_blink_mode);
  endtask

  // monitor: result words are checked before the word taken at the same edge is predicted,
  // since a result can never come out in the cycle its word goes in
  always @(posedge clk_i) begin : monitor
    crtc_res_t exp_w;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (res_due.size() == 0) begin
          $error("result word with nothing outstanding");
          errors++;
        end else begin
          check_word(res_due.pop_front(), res_o);
        end
      end
      if (start && !busy) begin
        exp_w = crtc_step(cmd_i);
        if (pin_chk) begin
          exp_w.read_data     = pin_rd;
          exp_w.read_unmapped = pin_unm;
        end
        res_due.push_back(exp_w);
        words_taken <= words_taken + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one word from a falling edge and hold it until the block takes it;
  // idle gaps land in front of about 17 words in 100,
  // except in a stretch of the random part that runs back to back
  task automatic send_word(input crtc_cmd_t w, input logic pin, input logic [7:0] rd,
                           input logic unm);
    int unsigned mark;
    mark = words_taken;
    if (!(n_sent >= 500 && n_sent < 800) && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start   <= 1'b1;
    cmd_i   <= w;
    pin_chk <= pin;
    pin_rd  <= rd;
    pin_unm <= unm;
    do @(negedge clk_i); while (words_taken == mark);
  endtask

  // random word with an arbitrary pen address riding along
  task automatic issue(input logic [2:0] f, input logic [7:0] d);
    crtc_cmd_t w;
    w.func      = f;
    w.data      = d;
    w.lpen_addr = ADDR_W'($urandom_range(0, 16383));
    if (f != FUNC_SPARE_A && f != FUNC_SPARE_B) n_sent++;
    send_word(w, 1'b0, 8'h00, 1'b0);
  endtask

  function automatic bus_row_t row(input logic [2:0] f, input logic [7:0] d,
                                   input logic [ADDR_W-1:0] lp, input logic pin,
                                   input logic [7:0] rd, input logic unm);
    bus_row_t b;
    b.cmd.func      = f;
    b.cmd.data      = d;
    b.cmd.lpen_addr = lp;
    b.pin           = pin;
    b.rd            = rd;
    b.unm           = unm;
    return b;
  endfunction

  initial begin : stimulus
    bus_row_t    table_rows[$];
    int unsigned pick;
    logic [4:0]  r;
    logic [7:0]  d;
    logic        timing;

    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    pin_chk = 1'b0;
    pin_rd  = '0;
    pin_unm = 1'b0;
    n_sent  = 0;

    // predictor reset state
    sel_reg = '0; h_total = '0; v_total = '0; v_adj = '0; v_disp = '0; row_lines = '0;
    cur_first = '0; cur_last = '0; blink_mode = '0; cur_addr = '0; disp_addr = '0;
    pen_latch = '0; pen_full = 1'b0; upd_latch = '0;
    frame_len = LEN_W'(1); blank_len = '0; phase = '0;

    // status after reset, then a read of a register with no read data
    table_rows.push_back(row(FUNC_STATUS, 8'h00, '0, 1'b1, STATUS_BASE, 1'b0));
    table_rows.push_back(row(FUNC_RD, 8'h00, '0, 1'b1, RD_UNMAPPED, 1'b1));
    // cursor high byte at its widest
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_CURSOR_HI}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'hFF, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_RD, 8'h00, '0, 1'b1, 8'h3F, 1'b0));
    // light pen: first strobe latches, second is dropped while full
    table_rows.push_back(row(FUNC_LPEN, 8'h00, 14'h3FFF, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_LPEN, 8'hFF, 14'h0000, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_STATUS, 8'h00, '0, 1'b1, 8'hC0, 1'b0));
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_LPEN_HI}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_RD, 8'h00, '0, 1'b1, 8'h3F, 1'b0));
    table_rows.push_back(row(FUNC_STATUS, 8'h00, '0, 1'b1, STATUS_BASE, 1'b0));
    // select byte with the upper bits set lands on the update strobe register
    table_rows.push_back(row(FUNC_SEL, 8'hFF, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'hA5, '0, 1'b0, 8'h00, 1'b0));
    // widest horizontal total with zero rows gives a zero frame, taken as one
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_HTOTAL}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'hFF, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_VTOTAL}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'h00, '0, 1'b0, 8'h00, 1'b0));
    // blanking as long as the frame: vblank stays up through the tick
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_LINES}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'h00, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_TICK, 8'h00, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_STATUS, 8'h00, '0, 1'b1, 8'hA0, 1'b0));
    table_rows.push_back(row(FUNC_SPARE_B, 8'hFF, 14'h3FFF, 1'b0, 8'h00, 1'b0));
    // displayed rows beyond total: stored now, blanking goes negative at the next
    // timing write and clamps to zero
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_VDISPLAYED}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'hFF, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_SEL, {3'b000, REG_VADJUST}, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_WR, 8'h1F, '0, 1'b0, 8'h00, 1'b0));
    table_rows.push_back(row(FUNC_STATUS, 8'h00, '0, 1'b1, STATUS_BASE, 1'b0));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i])
      send_word(table_rows[i].cmd, table_rows[i].pin, table_rows[i].rd, table_rows[i].unm);

    // random part: mostly select-then-access pairs and tick bursts; timing registers
    // get small values most of the time so frames stay a few dozen ticks long
    // and vblank keeps toggling
    n_sent = 0;
    while (n_sent < RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 8)) issue(FUNC_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            case ($urandom_range(0, 4))
              0: r = REG_HTOTAL;
              1: r = REG_VTOTAL;
              2: r = REG_VADJUST;
              3: r = REG_LINES;
              default: r = REG_VDISPLAYED;
            endcase
          end
          4, 5, 6, 7: r = 5'($urandom_range(REG_CUR_START, REG_UPD_LO));
          default: r = ($urandom_range(0, 3) == 0) ? REG_UPD_STROBE : 5'($urandom_range(0, 31));
        endcase
        timing = (r == REG_HTOTAL || r == REG_VTOTAL || r == REG_VADJUST ||
                  r == REG_LINES || r == REG_VDISPLAYED);
        d = (timing && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(0, 255));
        issue(FUNC_SEL, {3'($urandom_range(0, 7)), r});
        issue(FUNC_WR, d);
      end else if (pick < 75) begin
        r = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(REG_CURSOR_HI, REG_LPEN_LO))
                                        : 5'($urandom_range(0, 31));
        issue(FUNC_SEL, {3'($urandom_range(0, 7)), r});
        issue(FUNC_RD, 8'($urandom_range(0, 255)));
      end else if (pick < 83) begin
        issue(FUNC_STATUS, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        issue(FUNC_LPEN, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        // noise: any function code, spare ones included
        issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        // broken sequence: access with whatever register is still selected
        issue(($urandom_range(0, 1) == 0) ? FUNC_WR : FUNC_RD, 8'($urandom_range(0, 255)));
      end
    end

    // drop start at the falling edge right after the last word is taken
    start <= 1'b0;
    while (res_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0 && res_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
